@@ rtl/ppbd_pkg.sv @@
// ----------------------------------------------------------------------------
// ppbd_pkg
// Shared constants, command codes and control types for the pen plotter
// bitmap drawer.
// ----------------------------------------------------------------------------
package ppbd_pkg;

  // Frame buffer geometry.
  localparam int MAX_WIDTH  = 256;
  localparam int MAX_HEIGHT = 256;
  localparam int ADDR_W     = $clog2(MAX_WIDTH * MAX_HEIGHT);

  // Field widths of the command and result ports.
  localparam int FUNC_W = 3;
  localparam int STEP_W = 10;
  localparam int POS_W  = 8;
  localparam int SIZE_W = 9;

  // Largest usable grid size on each axis.
  localparam int LIM_WIDTH_I  = (MAX_WIDTH  < 256) ? MAX_WIDTH  : 256;
  localparam int LIM_HEIGHT_I = (MAX_HEIGHT < 256) ? MAX_HEIGHT : 256;
  localparam logic [SIZE_W-1:0] LIM_WIDTH  = SIZE_W'(LIM_WIDTH_I);
  localparam logic [SIZE_W-1:0] LIM_HEIGHT = SIZE_W'(LIM_HEIGHT_I);

  // Configuration port.
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;
  localparam logic REG_GRID_WIDTH  = 1'b0;
  localparam logic REG_GRID_HEIGHT = 1'b1;
  localparam logic [SIZE_W-1:0] GRID_RESET = SIZE_W'(256);

  // Command codes.
  localparam logic [FUNC_W-1:0] FUNC_LIFT  = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_LOWER = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_UP    = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_DOWN  = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_LEFT  = 3'd4;
  localparam logic [FUNC_W-1:0] FUNC_RIGHT = 3'd5;
  localparam logic [FUNC_W-1:0] FUNC_READ  = 3'd6;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;     // latch the accepted command
    logic pen_wr;   // update the pen flag
    logic pen_val;  // new pen flag
    logic step;     // take one unit step
    logic rd;       // read the addressed pixel
    logic clr;      // clear one frame buffer entry
  } ppbd_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic step_last;  // the current step is the final one
    logic clr_last;   // the clear pass is at its final entry
  } ppbd_stat_t;

  // Register value to usable grid size: zero acts as one, clamp at the limit.
  function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] r,
                                                 input logic [SIZE_W-1:0] lim);
    logic [SIZE_W-1:0] v;
    v = (r == '0) ? SIZE_W'(1) : r;
    if (v > lim) begin
      v = lim;
    end
    return v;
  endfunction

endpackage

@@ rtl/ppbd_regs.sv @@
// ----------------------------------------------------------------------------
// ppbd_regs
// Configuration registers behind the APB port: grid width and grid height.
// ----------------------------------------------------------------------------
module ppbd_regs (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ppbd_pkg::PADDR_W-1:0]  paddr,
  input  logic [ppbd_pkg::PDATA_W-1:0]  pwdata,
  output logic [ppbd_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready,
  output logic [ppbd_pkg::SIZE_W-1:0]   grid_width,
  output logic [ppbd_pkg::SIZE_W-1:0]   grid_height
);
  import ppbd_pkg::*;

  logic wr_en;
  logic reg_idx;

  // Registers sit on a 4-byte stride.
  assign reg_idx = paddr[2];
  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;

  // Register writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width  <= GRID_RESET;
      grid_height <= GRID_RESET;
    end else if (wr_en) begin
      case (reg_idx)
        REG_GRID_WIDTH:  grid_width  <= pwdata[SIZE_W-1:0];
        REG_GRID_HEIGHT: grid_height <= pwdata[SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  // Read data.
  always_comb begin
    case (reg_idx)
      REG_GRID_WIDTH:  prdata = PDATA_W'(grid_width);
      REG_GRID_HEIGHT: prdata = PDATA_W'(grid_height);
      default:         prdata = '0;
    endcase
  end

endmodule

@@ rtl/ppbd_ctrl.sv @@
// ----------------------------------------------------------------------------
// ppbd_ctrl
// Controller state machine: clears the frame buffer after reset, accepts
// commands, sequences unit steps and pixel reads, and strobes each result.
// ----------------------------------------------------------------------------
module ppbd_ctrl (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [ppbd_pkg::FUNC_W-1:0]   func,
  input  logic [ppbd_pkg::STEP_W-1:0]   step_count,
  input  ppbd_pkg::ppbd_stat_t          stat,
  output ppbd_pkg::ppbd_cmd_t           cmd,
  output logic                          busy,
  output logic                          done
);
  import ppbd_pkg::*;

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_MOVE  = 3'd2;
  localparam logic [2:0] S_READ  = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;

  // State register; reset starts the clearing pass.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Next state and datapath commands.
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_CLEAR: begin
        cmd.clr = 1'b1;
        if (stat.clr_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          case (func)
            FUNC_LIFT: begin
              cmd.pen_wr  = 1'b1;
              cmd.pen_val = 1'b0;
              state_next  = S_DONE;
            end
            FUNC_LOWER: begin
              cmd.pen_wr  = 1'b1;
              cmd.pen_val = 1'b1;
              state_next  = S_DONE;
            end
            FUNC_UP, FUNC_DOWN, FUNC_LEFT, FUNC_RIGHT: begin
              state_next = (step_count == '0) ? S_DONE : S_MOVE;
            end
            FUNC_READ: begin
              state_next = S_READ;
            end
            default: begin
              state_next = S_DONE;
            end
          endcase
        end
      end
      S_MOVE: begin
        cmd.step = 1'b1;
        if (stat.step_last) begin
          state_next = S_DONE;
        end
      end
      S_READ: begin
        cmd.rd     = 1'b1;
        state_next = S_DONE;
      end
      S_DONE: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign busy = (state != S_IDLE);
  assign done = (state == S_DONE);

`ifndef SYNTHESIS
  // A result never appears while a new command could be accepted.
  a_done_busy: assert property (@(posedge clk) disable iff (rst) done |-> busy)
    else $error("result strobe while idle");

  // An accepted command always makes the block busy.
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted command did not start");

  // A move keeps stepping until the last step is reported.
  a_move_hold: assert property (@(posedge clk) disable iff (rst)
    (state == S_MOVE && !stat.step_last) |=> (state == S_MOVE))
    else $error("move ended early");

  // Each result is strobed for exactly one cycle.
  a_done_pulse: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("result strobe longer than one cycle");
`endif

endmodule

@@ rtl/ppbd_dp.sv @@
// ----------------------------------------------------------------------------
// ppbd_dp
// Datapath: pen flag, pen position, step counter, bounds checks and the
// one-bit frame buffer memory.
// ----------------------------------------------------------------------------
module ppbd_dp (
  input  logic                          clk,
  input  logic                          rst,
  input  ppbd_pkg::ppbd_cmd_t           cmd,
  output ppbd_pkg::ppbd_stat_t          stat,
  input  logic [ppbd_pkg::FUNC_W-1:0]   func,
  input  logic [ppbd_pkg::STEP_W-1:0]   step_count,
  input  logic [ppbd_pkg::POS_W-1:0]    read_row,
  input  logic [ppbd_pkg::POS_W-1:0]    read_col,
  input  logic [ppbd_pkg::SIZE_W-1:0]   grid_width,
  input  logic [ppbd_pkg::SIZE_W-1:0]   grid_height,
  output logic [ppbd_pkg::POS_W-1:0]    pos_row,
  output logic [ppbd_pkg::POS_W-1:0]    pos_col,
  output logic                          pen_is_down,
  output logic                          pixel_value
);
  import ppbd_pkg::*;

  logic                 pen_down;
  logic [POS_W-1:0]     cur_row;
  logic [POS_W-1:0]     cur_col;
  logic [FUNC_W-1:0]    dir;
  logic [STEP_W-1:0]    remaining;
  logic [POS_W-1:0]     rd_row;
  logic [POS_W-1:0]     rd_col;
  logic                 pix_sel;
  logic                 mem_q;
  logic [ADDR_W-1:0]    clr_addr;
  logic                 frame_mem [MAX_WIDTH*MAX_HEIGHT];

  logic [SIZE_W-1:0]    ew;
  logic [SIZE_W-1:0]    eh;
  logic [SIZE_W-1:0]    row_x;
  logic [SIZE_W-1:0]    col_x;
  logic [POS_W-1:0]     row_next;
  logic [POS_W-1:0]     col_next;
  logic                 mark_ok;
  logic                 rd_in_grid;
  logic                 mem_we;
  logic [ADDR_W-1:0]    mem_waddr;
  logic                 mem_wdata;
  logic [ADDR_W-1:0]    mem_raddr;

  // Row-major frame buffer address with a fixed row pitch.
  function automatic logic [ADDR_W-1:0] cell_addr(input logic [POS_W-1:0] r,
                                                  input logic [POS_W-1:0] c);
    return ADDR_W'(32'(r) * MAX_WIDTH + 32'(c));
  endfunction

  assign ew    = eff_size(grid_width, LIM_WIDTH);
  assign eh    = eff_size(grid_height, LIM_HEIGHT);
  assign row_x = {1'b0, cur_row};
  assign col_x = {1'b0, cur_col};

  // One unit step: the move is skipped if the new coordinate leaves the grid.
  always_comb begin
    row_next = cur_row;
    col_next = cur_col;
    case (dir)
      FUNC_UP: begin
        if (cur_row != '0 && (row_x - SIZE_W'(1)) < eh) begin
          row_next = cur_row - POS_W'(1);
        end
      end
      FUNC_DOWN: begin
        if ((row_x + SIZE_W'(1)) < eh) begin
          row_next = cur_row + POS_W'(1);
        end
      end
      FUNC_LEFT: begin
        if (cur_col != '0 && (col_x - SIZE_W'(1)) < ew) begin
          col_next = cur_col - POS_W'(1);
        end
      end
      FUNC_RIGHT: begin
        if ((col_x + SIZE_W'(1)) < ew) begin
          col_next = cur_col + POS_W'(1);
        end
      end
      default: ;
    endcase
  end

  // The pixel under the pen is marked only if it lies inside the buffer.
  assign mark_ok = pen_down && (32'(row_next) < MAX_HEIGHT) && (32'(col_next) < MAX_WIDTH);

  // Reads outside the configured grid return zero.
  assign rd_in_grid = ({1'b0, rd_row} < eh) && ({1'b0, rd_col} < ew);

  // Memory write port: the clearing pass or a pen mark.
  assign mem_we    = cmd.clr || (cmd.step && mark_ok);
  assign mem_waddr = cmd.clr ? clr_addr : cell_addr(row_next, col_next);
  assign mem_wdata = !cmd.clr;
  assign mem_raddr = cell_addr(rd_row, rd_col);

  // Clearing pass address.
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clr) begin
      clr_addr <= clr_addr + ADDR_W'(1);
    end
  end

  // Pen flag and position.
  always_ff @(posedge clk) begin
    if (rst) begin
      pen_down <= 1'b0;
      cur_row  <= '0;
      cur_col  <= '0;
    end else begin
      if (cmd.pen_wr) begin
        pen_down <= cmd.pen_val;
      end
      if (cmd.step) begin
        cur_row <= row_next;
        cur_col <= col_next;
      end
    end
  end

  // Latched command fields and step counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      pix_sel <= 1'b0;
    end else if (cmd.load) begin
      pix_sel <= 1'b0;
    end else if (cmd.rd) begin
      pix_sel <= rd_in_grid;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      dir       <= func;
      remaining <= step_count;
      rd_row    <= read_row;
      rd_col    <= read_col;
    end else if (cmd.step) begin
      remaining <= remaining - STEP_W'(1);
    end
  end

  // Frame buffer memory.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      frame_mem[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd) begin
      mem_q <= frame_mem[mem_raddr];
    end
  end

  assign stat.step_last = (remaining == STEP_W'(1));
  assign stat.clr_last  = (clr_addr == '1);

  assign pos_row     = cur_row;
  assign pos_col     = cur_col;
  assign pen_is_down = pen_down;
  assign pixel_value = pix_sel & mem_q;

endmodule

@@ rtl/pen_plotter_bitmap_drawer.sv @@
// ----------------------------------------------------------------------------
// pen_plotter_bitmap_drawer
// Pen-arm drawing engine over a one-bit frame buffer, with pen lift and
// lower, unit-step moves with per-axis bounds checks, and pixel reads.
// ----------------------------------------------------------------------------
//
//   Channel   Handshake                    Payload
//   -------   --------------------------   ---------------------------------
//   command   start, busy (accept on       func, step_count, read_row,
//             start high and busy low)     read_col
//   result    done (one-cycle strobe)      pos_row, pos_col, pen_is_down,
//                                          pixel_value
//   config    APB psel/penable/pwrite      paddr, pwdata, prdata, pready
//
// A move steps in S_MOVE until its count runs out, then strobes: one frame
// buffer write port takes one step per cycle. Pen and unused commands go
// straight to the strobe; a pixel read passes through the registered memory
// read. After reset the block clears its 65536-entry frame buffer one entry
// per cycle and holds busy high for the whole pass; configuration writes are
// taken during that pass. The receiver cannot stall: each result is shown for
// one cycle and the next command is taken in the cycle after the strobe.
//
module pen_plotter_bitmap_drawer (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [ppbd_pkg::FUNC_W-1:0]   func,
  input  logic [ppbd_pkg::STEP_W-1:0]   step_count,
  input  logic [ppbd_pkg::POS_W-1:0]    read_row,
  input  logic [ppbd_pkg::POS_W-1:0]    read_col,
  output logic                          done,
  output logic [ppbd_pkg::POS_W-1:0]    pos_row,
  output logic [ppbd_pkg::POS_W-1:0]    pos_col,
  output logic                          pen_is_down,
  output logic                          pixel_value,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ppbd_pkg::PADDR_W-1:0]  paddr,
  input  logic [ppbd_pkg::PDATA_W-1:0]  pwdata,
  output logic [ppbd_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready
);
  import ppbd_pkg::*;

  ppbd_cmd_t          cmd;
  ppbd_stat_t         stat;
  logic [SIZE_W-1:0]  grid_width;
  logic [SIZE_W-1:0]  grid_height;

  // Configuration registers.
  ppbd_regs u_regs (
    .clk         (clk),
    .rst         (rst),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .grid_width  (grid_width),
    .grid_height (grid_height)
  );

  // Command sequencing.
  ppbd_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .func       (func),
    .step_count (step_count),
    .stat       (stat),
    .cmd        (cmd),
    .busy       (busy),
    .done       (done)
  );

  // Position, pen and frame buffer.
  ppbd_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .func        (func),
    .step_count  (step_count),
    .read_row    (read_row),
    .read_col    (read_col),
    .grid_width  (grid_width),
    .grid_height (grid_height),
    .pos_row     (pos_row),
    .pos_col     (pos_col),
    .pen_is_down (pen_is_down),
    .pixel_value (pixel_value)
  );

endmodule

@@ bench/ppbd_checker.sv @@
// ----------------------------------------------------------------------------
// ppbd_checker
// Result checker for the pen plotter bitmap drawer. It follows the command
// and configuration traffic, keeps its own copy of the pen, the position and
// the drawn picture, and compares every result strobe with its prediction.
// ----------------------------------------------------------------------------
module ppbd_checker
  import ppbd_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic               busy,
  input  logic [FUNC_W-1:0]  func,
  input  logic [STEP_W-1:0]  step_count,
  input  logic [POS_W-1:0]   read_row,
  input  logic [POS_W-1:0]   read_col,
  input  logic               done,
  input  logic [POS_W-1:0]   pos_row,
  input  logic [POS_W-1:0]   pos_col,
  input  logic               pen_is_down,
  input  logic               pixel_value,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic               pready,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output int                 fail_count,
  output int                 pending
);

  typedef struct packed {
    logic [POS_W-1:0] row;
    logic [POS_W-1:0] col;
    logic             pen;
    logic             pix;
  } plot_report_t;

  // Shadow of the block's registers and drawing state.
  logic [SIZE_W-1:0] width_reg;
  logic [SIZE_W-1:0] height_reg;
  logic              pen_lowered;
  int unsigned       pen_row;
  int unsigned       pen_col;
  bit                drawn [0:MAX_WIDTH*MAX_HEIGHT-1];
  plot_report_t      awaited_reports [$];
  int                errors = 0;

  // Register value to the grid size actually in use on one axis.
  function automatic int unsigned usable_size(input logic [SIZE_W-1:0] r,
                                              input int unsigned lim);
    int unsigned v;
    v = (r == '0) ? 1 : r;
    if (v > lim) begin
      v = lim;
    end
    if (v > 256) begin
      v = 256;
    end
    return v;
  endfunction

  // Set the pixel under the pen when it is lowered.
  function automatic void ink_pixel();
    if (pen_lowered && pen_row < MAX_HEIGHT && pen_col < MAX_WIDTH) begin
      drawn[pen_row * MAX_WIDTH + pen_col] = 1'b1;
    end
  endfunction

  // Apply one command to the shadow state and return the report it yields.
  function automatic plot_report_t plot_command(input logic [FUNC_W-1:0] f,
                                                input logic [STEP_W-1:0] n,
                                                input logic [POS_W-1:0] r,
                                                input logic [POS_W-1:0] c);
    plot_report_t rep;
    int unsigned  ew;
    int unsigned  eh;
    logic         pix;
    ew  = usable_size(width_reg, MAX_WIDTH);
    eh  = usable_size(height_reg, MAX_HEIGHT);
    pix = 1'b0;
    case (f)
      FUNC_LIFT:  pen_lowered = 1'b0;
      FUNC_LOWER: pen_lowered = 1'b1;
      FUNC_UP, FUNC_DOWN, FUNC_LEFT, FUNC_RIGHT: begin
        // Each unit step is checked against its own axis; a skipped step
        // still inks the pixel under the pen.
        for (int i = 0; i < n; i++) begin
          case (f)
            FUNC_UP: begin
              if (pen_row >= 1 && pen_row - 1 < eh) pen_row = pen_row - 1;
            end
            FUNC_DOWN: begin
              if (pen_row + 1 < eh) pen_row = pen_row + 1;
            end
            FUNC_LEFT: begin
              if (pen_col >= 1 && pen_col - 1 < ew) pen_col = pen_col - 1;
            end
            default: begin
              if (pen_col + 1 < ew) pen_col = pen_col + 1;
            end
          endcase
          ink_pixel();
        end
      end
      FUNC_READ: begin
        if (r < eh && c < ew) begin
          pix = drawn[r * MAX_WIDTH + c];
        end
      end
      default: ;
    endcase
    rep.row = pen_row[POS_W-1:0];
    rep.col = pen_col[POS_W-1:0];
    rep.pen = pen_lowered;
    rep.pix = pix;
    return rep;
  endfunction

  task automatic compare_field(input string name, input int unsigned want,
                               input int unsigned got);
    if (want != got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  // Results are matched before new commands are taken in, so a strobe is
  // never paired with the command accepted at the same edge.
  always @(posedge clk) begin
    plot_report_t want;
    if (rst) begin
      width_reg   = GRID_RESET;
      height_reg  = GRID_RESET;
      pen_lowered = 1'b0;
      pen_row     = 0;
      pen_col     = 0;
      foreach (drawn[a]) drawn[a] = 1'b0;
      awaited_reports.delete();
    end else begin
      if (done) begin
        if (awaited_reports.size() == 0) begin
          errors++;
          $display("%0t: result with no command outstanding, expected none, actual %0d,%0d",
                   $time, pos_row, pos_col);
        end else begin
          want = awaited_reports.pop_front();
          compare_field("pos_row", want.row, pos_row);
          compare_field("pos_col", want.col, pos_col);
          compare_field("pen_is_down", want.pen, pen_is_down);
          compare_field("pixel_value", want.pix, pixel_value);
        end
      end
      if (psel && penable && pwrite && pready) begin
        if (paddr == {REG_GRID_WIDTH, 2'b00}) begin
          width_reg = pwdata[SIZE_W-1:0];
        end else if (paddr == {REG_GRID_HEIGHT, 2'b00}) begin
          height_reg = pwdata[SIZE_W-1:0];
        end
      end
      if (start && !busy) begin
        awaited_reports.push_back(plot_command(func, step_count, read_row, read_col));
      end
    end
    pending    <= awaited_reports.size();
    fail_count <= errors;
  end

endmodule

@@ bench/tb_pen_plotter_bitmap_drawer.sv @@
// ----------------------------------------------------------------------------
// tb_pen_plotter_bitmap_drawer
// Drives pen, move and pixel read commands into the plotter with random
// gaps, reshapes the drawing grid between phases over the register port,
// and reports the verdict from the checker's failure count.
// ----------------------------------------------------------------------------
module tb_pen_plotter_bitmap_drawer;
  import ppbd_pkg::*;

  // Command code with no function assigned.
  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 3'd7;

  logic               clk;
  logic               rst;
  logic               start;
  logic               busy;
  logic [FUNC_W-1:0]  func;
  logic [STEP_W-1:0]  step_count;
  logic [POS_W-1:0]   read_row;
  logic [POS_W-1:0]   read_col;
  logic               done;
  logic [POS_W-1:0]   pos_row;
  logic [POS_W-1:0]   pos_col;
  logic               pen_is_down;
  logic               pixel_value;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;
  int                 fail_count;
  int                 pending;
  logic [POS_W-1:0]   last_row;
  logic [POS_W-1:0]   last_col;
  bit                 gaps_on;

  pen_plotter_bitmap_drawer uut (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .func        (func),
    .step_count  (step_count),
    .read_row    (read_row),
    .read_col    (read_col),
    .done        (done),
    .pos_row     (pos_row),
    .pos_col     (pos_col),
    .pen_is_down (pen_is_down),
    .pixel_value (pixel_value),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  ppbd_checker plot_check (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .func        (func),
    .step_count  (step_count),
    .read_row    (read_row),
    .read_col    (read_col),
    .done        (done),
    .pos_row     (pos_row),
    .pos_col     (pos_col),
    .pen_is_down (pen_is_down),
    .pixel_value (pixel_value),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .pready      (pready),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .fail_count  (fail_count),
    .pending     (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // The last reported position steers reads toward freshly drawn pixels.
  always @(posedge clk) begin
    if (done) begin
      last_row <= pos_row;
      last_col <= pos_col;
    end
  end

  // Present one command and hold it until the block takes it.
  task automatic send_command(input logic [FUNC_W-1:0] f, input logic [STEP_W-1:0] n,
                              input logic [POS_W-1:0] r, input logic [POS_W-1:0] c);
    start      <= 1'b1;
    func       <= f;
    step_count <= n;
    read_row   <= r;
    read_col   <= c;
    do @(posedge clk); while (busy);
  endtask

  // Stop sending and wait until every outstanding transaction has reported.
  task automatic settle();
    start <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  // One register write: setup phase, access phase, then a rest with the bus idle.
  task automatic write_reg(input logic [PADDR_W-1:0] addr, input logic [PDATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // Upper data bits are noise; only the low bits hold the size.
  task automatic configure_grid(input logic [SIZE_W-1:0] w, input logic [SIZE_W-1:0] h);
    logic [PDATA_W-1:0] data;
    data = $urandom();
    data[SIZE_W-1:0] = w;
    write_reg({REG_GRID_WIDTH, 2'b00}, data);
    data = $urandom();
    data[SIZE_W-1:0] = h;
    write_reg({REG_GRID_HEIGHT, 2'b00}, data);
  endtask

  function automatic logic [SIZE_W-1:0] random_size();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 85) begin
      return SIZE_W'($urandom_range(1, 256));
    end else if (roll < 92) begin
      return '0;
    end
    return SIZE_W'($urandom_range(257, 511));
  endfunction

  // Mostly back to back, sometimes a short pause, rarely a long one.
  task automatic idle_gap();
    int roll;
    int gap;
    roll = $urandom_range(0, 99);
    if (roll < 65) begin
      gap = 0;
    end else if (roll < 93) begin
      gap = $urandom_range(1, 4);
    end else begin
      gap = $urandom_range(15, 60);
    end
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Random command: mostly moves of a few steps, with reads near the pen.
  task automatic draw_random();
    logic [FUNC_W-1:0] f;
    logic [STEP_W-1:0] n;
    logic [POS_W-1:0]  r;
    logic [POS_W-1:0]  c;
    int                roll;
    roll = $urandom_range(0, 99);
    if (roll < 8) begin
      f = FUNC_LIFT;
    end else if (roll < 18) begin
      f = FUNC_LOWER;
    end else if (roll < 70) begin
      case ($urandom_range(0, 3))
        0:       f = FUNC_UP;
        1:       f = FUNC_DOWN;
        2:       f = FUNC_LEFT;
        default: f = FUNC_RIGHT;
      endcase
    end else if (roll < 96) begin
      f = FUNC_READ;
    end else begin
      f = FUNC_UNUSED;
    end
    roll = $urandom_range(0, 99);
    if (roll < 5) begin
      n = '0;
    end else if (roll < 75) begin
      n = STEP_W'($urandom_range(1, 15));
    end else if (roll < 95) begin
      n = STEP_W'($urandom_range(16, 300));
    end else if (roll < 99) begin
      n = STEP_W'($urandom_range(301, 1022));
    end else begin
      n = '1;
    end
    if ($urandom_range(0, 99) < 60) begin
      r = last_row + POS_W'($urandom_range(0, 6)) - POS_W'(3);
      c = last_col + POS_W'($urandom_range(0, 6)) - POS_W'(3);
    end else begin
      r = POS_W'($urandom_range(0, 255));
      c = POS_W'($urandom_range(0, 255));
    end
    send_command(f, n, r, c);
  endtask

  // Stimulus and verdict.
  initial begin
    rst        <= 1'b1;
    start      <= 1'b0;
    func       <= FUNC_LIFT;
    step_count <= '0;
    read_row   <= '0;
    read_col   <= '0;
    psel       <= 1'b0;
    penable    <= 1'b0;
    pwrite     <= 1'b0;
    paddr      <= '0;
    pwdata     <= '0;
    last_row   <= '0;
    last_col   <= '0;
    gaps_on    = 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Full grid; these writes land during the frame buffer clear pass.
    configure_grid(256, 256);

    // Directed: corners, pen up travel, clamping at every edge, odd codes.
    send_command(FUNC_READ, '0, 8'd0, 8'd0);
    send_command(FUNC_READ, '1, 8'd255, 8'd255);
    send_command(FUNC_RIGHT, 10'd7, 8'd0, 8'd0);
    send_command(FUNC_READ, '0, 8'd0, 8'd7);
    send_command(FUNC_LOWER, '0, 8'd0, 8'd0);
    send_command(FUNC_READ, '0, 8'd0, 8'd7);
    send_command(FUNC_RIGHT, '0, 8'd0, 8'd0);
    send_command(FUNC_DOWN, 10'd3, 8'd0, 8'd0);
    send_command(FUNC_UP, '1, 8'd0, 8'd0);
    send_command(FUNC_LEFT, '1, 8'd0, 8'd0);
    send_command(FUNC_READ, '0, 8'd0, 8'd0);
    send_command(FUNC_READ, '0, 8'd2, 8'd7);
    send_command(FUNC_RIGHT, '1, 8'd0, 8'd0);
    send_command(FUNC_DOWN, '1, 8'd0, 8'd0);
    send_command(FUNC_READ, '0, 8'd255, 8'd255);
    send_command(FUNC_READ, '0, 8'd128, 8'd255);
    send_command(FUNC_UNUSED, 10'h155, 8'hAA, 8'h55);
    send_command(FUNC_LIFT, 10'h2AA, 8'h55, 8'hAA);
    send_command(FUNC_LEFT, 10'd1, 8'd0, 8'd0);
    send_command(FUNC_READ, '0, 8'd255, 8'd254);
    send_command(FUNC_LOWER, '0, 8'd0, 8'd0);

    // Shrink the grid under the pen: it stays outside yet keeps inking.
    settle();
    configure_grid(9, 5);
    send_command(FUNC_UP, 10'd4, 8'd0, 8'd0);
    send_command(FUNC_READ, '0, 8'd255, 8'd254);
    send_command(FUNC_READ, '0, 8'd4, 8'd8);
    send_command(FUNC_LEFT, 10'd300, 8'd0, 8'd0);

    // Random phases, each under its own grid setting.
    for (int ph = 0; ph < 9; ph++) begin
      settle();
      case (ph)
        0:       configure_grid(1, 1);
        1:       configure_grid(0, 511);
        2:       configure_grid(511, 0);
        3:       configure_grid(256, 256);
        4:       configure_grid(2, 256);
        default: configure_grid(random_size(), random_size());
      endcase
      for (int k = 0; k < 72; k++) begin
        if (k % 16 == 0) begin
          gaps_on = ($urandom_range(0, 3) != 0);
        end
        if (gaps_on) begin
          idle_gap();
        end
        draw_random();
      end
    end

    settle();
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Guard against a hung handshake.
  initial begin
    #40_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule
